// ----- rtl/at_pkg.sv -----
// shared types and constants for the argument tokenizer
package at_pkg;

  localparam int AT_MAX_CAPACITY = 4096;
  localparam int AT_QUEUE_DEPTH  = 4;
  localparam int AT_LIMIT_W      = 13;
  localparam int AT_CFG_IDX_W    = 1;
  localparam int AT_SLOTS        = 3;

  localparam logic [AT_LIMIT_W-1:0] AT_LIMIT_RESET = 13'd4096;

  // configuration register indexes
  typedef enum logic [AT_CFG_IDX_W-1:0] {
    AT_CFG_STORE_QUOTES = 1'b0,
    AT_CFG_BUFFER_LIMIT = 1'b1
  } at_cfg_idx_e;

  // special line bytes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5c;

  // open quote tracking
  typedef enum logic [2:0] {
    QS_NONE   = 3'b001,
    QS_SINGLE = 3'b010,
    QS_DOUBLE = 3'b100
  } at_quote_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_separator;
    logic       end_of_line;
    logic [7:0] arg_count;
    logic       overflow;
  } at_result_t;

  // results of one input byte: escaped/backslash, byte or separator, terminator
  typedef struct packed {
    logic       [AT_SLOTS-1:0] valid;
    at_result_t [AT_SLOTS-1:0] res;
  } at_packet_t;

endpackage

// ----- rtl/at_if.sv -----
// channel interfaces: line bytes in, tokenized results out
interface at_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface at_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_separator;
  logic       end_of_line;
  logic [7:0] arg_count;
  logic       overflow;
  logic       last;

  modport source (output valid, output out_byte, output is_separator, output end_of_line,
                  output arg_count, output overflow, output last, input ready);
  modport sink   (input valid, input out_byte, input is_separator, input end_of_line,
                  input arg_count, input overflow, input last, output ready);
endinterface

// ----- rtl/at_front.sv -----
// front end: config registers, byte classification and tokenizer state
module at_front #(
  parameter int MaxCapacity = at_pkg::AT_MAX_CAPACITY
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  at_in_if.sink                        in_i,
  input  logic                         cfg_we_i,
  input  logic [at_pkg::AT_CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [at_pkg::AT_LIMIT_W-1:0]   cfg_wdata_i,
  input  logic                         full_i,
  output logic                         push_o,
  output at_pkg::at_packet_t           pkt_o
);
  import at_pkg::*;

  localparam int CapW = $clog2(MaxCapacity + 1);
  localparam int CmpW = (CapW > AT_LIMIT_W) ? CapW : AT_LIMIT_W;

  logic                  store_quotes_q;
  logic [AT_LIMIT_W-1:0] limit_q;

  at_quote_e   qs_q, qs_d;
  logic        pw_q, pw_d;
  logic        esc_q, esc_d;
  logic [CapW-1:0] used_q, used_d;
  logic [7:0]  args_q, args_d;
  logic        ovf_q, ovf_d;

  logic [CmpW-1:0] lim_ext, max_ext;
  logic [CapW-1:0] cap;
  logic [7:0]  qch, ch, byte_a;
  logic        consumed, req_b, sep_b, eol, accept;
  at_packet_t  pkt;

  assign ch     = in_i.ch;
  assign accept = in_i.valid && !full_i;
  assign in_i.ready = !full_i;

  // effective capacity is the smaller of the register and the build limit
  assign lim_ext = CmpW'(limit_q);
  assign max_ext = CmpW'(MaxCapacity);
  assign cap     = (lim_ext > max_ext) ? max_ext[CapW-1:0] : lim_ext[CapW-1:0];

  always_comb begin
    qs_d     = qs_q;
    pw_d     = pw_q;
    esc_d    = esc_q;
    used_d   = used_q;
    args_d   = args_q;
    ovf_d    = ovf_q;
    pkt      = '0;
    consumed = 1'b0;
    byte_a   = CH_BSLASH;
    req_b    = 1'b0;
    sep_b    = 1'b0;
    eol      = 1'b0;

    unique case (qs_q)
      QS_SINGLE: qch = CH_SQUOTE;
      QS_DOUBLE: qch = CH_DQUOTE;
      default:   qch = CH_NUL;
    endcase

    // held backslash from inside a quote
    if (esc_q) begin
      esc_d = 1'b0;
      if (qs_q != QS_NONE && ch == qch) begin
        byte_a   = ch;
        consumed = 1'b1;
      end
      if (({1'b0, used_d} + 1'b1) < {1'b0, cap}) begin
        used_d       = used_d + 1'b1;
        pkt.valid[0] = 1'b1;
        pkt.res[0]   = '{byte_a, 1'b0, 1'b0, args_d, ovf_d};
      end else begin
        ovf_d = 1'b1;
      end
    end

    if (!consumed) begin
      if (ch == CH_NUL) begin
        qs_d = QS_NONE;
        if (!pw_d) begin
          pw_d   = 1'b1;
          args_d = (args_d != 8'hff) ? args_d + 1'b1 : args_d;
          req_b  = 1'b1;
          sep_b  = 1'b1;
        end
        eol = 1'b1;
      end else if (ch == CH_SPACE || ch == CH_TAB) begin
        if (qs_d == QS_NONE) begin
          if (!pw_d) begin
            pw_d   = 1'b1;
            args_d = (args_d != 8'hff) ? args_d + 1'b1 : args_d;
            req_b  = 1'b1;
            sep_b  = 1'b1;
          end
        end else begin
          pw_d  = 1'b0;
          req_b = 1'b1;
        end
      end else if (ch == CH_SQUOTE || ch == CH_DQUOTE) begin
        pw_d = 1'b0;
        if (qs_d == QS_NONE) begin
          qs_d  = (ch == CH_SQUOTE) ? QS_SINGLE : QS_DOUBLE;
          req_b = store_quotes_q;
        end else if (ch == qch) begin
          qs_d  = QS_NONE;
          req_b = store_quotes_q;
        end else begin
          req_b = 1'b1;
        end
      end else if (ch == CH_BSLASH && qs_d != QS_NONE) begin
        pw_d  = 1'b0;
        esc_d = 1'b1;
      end else begin
        pw_d  = 1'b0;
        req_b = 1'b1;
      end
    end

    if (req_b) begin
      if (({1'b0, used_d} + 1'b1) < {1'b0, cap}) begin
        used_d       = used_d + 1'b1;
        pkt.valid[1] = 1'b1;
        pkt.res[1]   = '{(sep_b ? CH_NUL : ch), sep_b, 1'b0, args_d, ovf_d};
      end else begin
        ovf_d = 1'b1;
      end
    end

    // line end: terminator, then back to the idle line state
    if (eol) begin
      if (cap == '0) begin
        ovf_d = 1'b1;
      end
      pkt.valid[2] = 1'b1;
      pkt.res[2]   = '{CH_NUL, 1'b0, 1'b1, args_d, ovf_d};
      qs_d   = QS_NONE;
      pw_d   = 1'b1;
      esc_d  = 1'b0;
      used_d = '0;
      args_d = '0;
      ovf_d  = 1'b0;
    end
  end

  assign push_o = accept && (pkt.valid != '0);
  assign pkt_o  = pkt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_quotes_q <= 1'b0;
      limit_q        <= AT_LIMIT_RESET;
    end else if (cfg_we_i) begin
      unique case (at_cfg_idx_e'(cfg_idx_i))
        AT_CFG_STORE_QUOTES: store_quotes_q <= cfg_wdata_i[0];
        AT_CFG_BUFFER_LIMIT: limit_q        <= cfg_wdata_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qs_q   <= QS_NONE;
      pw_q   <= 1'b1;
      esc_q  <= 1'b0;
      used_q <= '0;
      args_q <= '0;
      ovf_q  <= 1'b0;
    end else if (accept) begin
      qs_q   <= qs_d;
      pw_q   <= pw_d;
      esc_q  <= esc_d;
      used_q <= used_d;
      args_q <= args_d;
      ovf_q  <= ovf_d;
    end
  end

endmodule

// ----- rtl/at_queue.sv -----
// small packet queue between front and back
module at_queue #(
  parameter int Depth = at_pkg::AT_QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  at_pkg::at_packet_t pkt_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               head_valid_o,
  output at_pkg::at_packet_t head_o
);
  import at_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  at_packet_t          mem_q [Depth];
  logic [PtrW-1:0]     wr_q, rd_q;
  logic [CntW-1:0]     cnt_q, cnt_d;

  assign full_o       = (cnt_q == CntW'(Depth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= pkt_i;
    end
  end

endmodule

// ----- rtl/at_back.sv -----
// back end: walks the results of each packet into the output register
module at_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_valid_i,
  input  at_pkg::at_packet_t head_i,
  output logic               pop_o,
  at_out_if.source           out_o
);
  import at_pkg::*;

  logic [AT_SLOTS-1:0] sent_q, sent_d, rem, pick, rest;
  logic                load, valid_q, last_q;
  at_result_t          sel, res_q;

  assign rem  = head_valid_i ? (head_i.valid & ~sent_q) : '0;
  assign pick = rem & (~rem + 1'b1);
  assign rest = rem & ~pick;
  assign load = (rem != '0) && (!valid_q || out_o.ready);
  assign pop_o = load && (rest == '0);

  always_comb begin
    sel = '0;
    for (int i = 0; i < AT_SLOTS; i++) begin
      if (pick[i]) begin
        sel = sel | head_i.res[i];
      end
    end
  end

  always_comb begin
    sent_d = sent_q;
    if (pop_o) begin
      sent_d = '0;
    end else if (load) begin
      sent_d = sent_q | pick;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sent_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      sent_q <= sent_d;
      if (load) begin
        valid_q <= 1'b1;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q  <= sel;
      last_q <= (rest == '0);
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.out_byte     = res_q.out_byte;
  assign out_o.is_separator = res_q.is_separator;
  assign out_o.end_of_line  = res_q.end_of_line;
  assign out_o.arg_count    = res_q.arg_count;
  assign out_o.overflow     = res_q.overflow;
  assign out_o.last         = last_q;

endmodule

// ----- rtl/argument_tokenizer.sv -----
// top level of the command-line argument tokenizer
//
//   channel   dir  beat contents
//   in_i      in   ch: one line byte, zero ends the line
//   out_o     out  out_byte, is_separator, end_of_line, arg_count, overflow, last
//   cfg       in   cfg_we_i / cfg_idx_i / cfg_wdata_i: store_quotes, buffer_limit
//
// the front takes one byte per cycle and decides all its results in that cycle
// a byte yields zero to three results; the back emits one result per cycle from
// its output register, so the sustained rate is one byte per cycle while bytes
// give at most one result each, and the output port limits it otherwise
// reset is asynchronous and needs no clearing pass; config is taken any cycle
// a stalled output only stops the front once the four-entry packet queue fills
module argument_tokenizer #(
  parameter int MaxCapacity = at_pkg::AT_MAX_CAPACITY
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  at_in_if.sink                           in_i,
  at_out_if.source                        out_o,
  input  logic                            cfg_we_i,
  input  logic [at_pkg::AT_CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [at_pkg::AT_LIMIT_W-1:0]   cfg_wdata_i
);
  import at_pkg::*;

  // front to queue
  logic       push, full;
  at_packet_t push_pkt;

  // queue to back
  logic       pop, head_valid;
  at_packet_t head_pkt;

  // classification, quote and escape tracking, capacity accounting
  at_front #(
    .MaxCapacity (MaxCapacity)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .full_i      (full),
    .push_o      (push),
    .pkt_o       (push_pkt)
  );

  // decouples byte intake from result delivery
  at_queue #(
    .Depth (AT_QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .pkt_i        (push_pkt),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head_pkt)
  );

  // serializes each packet, marks the last result of every byte
  at_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_pkt),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

// ----- bench/tb_top.sv -----
// testbench for the argument tokenizer: a directed line and random line bytes against a built-in predictor
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import at_pkg::*;

  // clock and reset
  logic clk_i = 1'b0;
  logic rst_ni;

  always #4 clk_i = ~clk_i;

  // channels and configuration port
  at_in_if  line_if ();
  at_out_if tok_if ();

  logic                    cfg_we_i;
  logic [AT_CFG_IDX_W-1:0] cfg_idx_i;
  logic [AT_LIMIT_W-1:0]   cfg_wdata_i;

  argument_tokenizer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (line_if),
    .out_o      (tok_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // one result beat as seen on the output channel
  typedef struct packed {
    at_result_t res;
    logic       last;
  } tok_beat_t;

  // line bytes waiting for the driver, results waiting for the output
  logic [7:0] line_bytes_q [$];
  tok_beat_t  due_beats_q  [$];
  tok_beat_t  step_beats_q [$];

  int  bytes_queued;
  int  bytes_taken;
  int  mismatch_count;
  bit  idle_on;
  bit  line_beat_taken;
  int  line_gap;
  int  sink_stall;

  // predictor copy of the registers
  logic                  keep_quotes;
  logic [AT_LIMIT_W-1:0] limit_reg;

  // predictor copy of the line state
  at_quote_e             open_quote;
  logic                  between_args;
  logic                  escape_held;
  logic [AT_LIMIT_W-1:0] slots_used;
  logic [7:0]            args_seen;
  logic                  dropped_any;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_line_state();
    open_quote   = QS_NONE;
    between_args = 1'b1;
    escape_held  = 1'b0;
    slots_used   = '0;
    args_seen    = '0;
    dropped_any  = 1'b0;
  endfunction

  // usable slots, clamped to the build capacity
  function automatic int usable_slots();
    return (int'(limit_reg) > AT_MAX_CAPACITY) ? AT_MAX_CAPACITY : int'(limit_reg);
  endfunction

  function automatic logic [7:0] open_quote_byte();
    case (open_quote)
      QS_SINGLE: return CH_SQUOTE;
      QS_DOUBLE: return CH_DQUOTE;
      default:   return CH_NUL;
    endcase
  endfunction

  function automatic void add_result(logic [7:0] b, logic sep, logic eol);
    tok_beat_t beat;
    beat.res.out_byte     = b;
    beat.res.is_separator = sep;
    beat.res.end_of_line  = eol;
    beat.res.arg_count    = args_seen;
    beat.res.overflow     = dropped_any;
    beat.last             = 1'b0;
    step_beats_q.push_back(beat);
  endfunction

  // one slot is kept back for the terminator
  function automatic void store_byte(logic [7:0] b, logic sep);
    int cap;
    cap = usable_slots();
    if (cap > 0 && int'(slots_used) < cap - 1) begin
      slots_used++;
      add_result(b, sep, 1'b0);
    end else begin
      dropped_any = 1'b1;
    end
  endfunction

  // a dropped separator still counts its argument
  function automatic void close_argument();
    if (!between_args) begin
      between_args = 1'b1;
      if (args_seen != 8'd255) args_seen++;
      store_byte(CH_NUL, 1'b1);
    end
  endfunction

  // works out the results of one accepted line byte
  function automatic void tokenize_byte(logic [7:0] ch);
    bit consumed;
    consumed = 1'b0;
    step_beats_q.delete();

    // a held backslash either escapes the open quote or is kept as it is
    if (escape_held) begin
      escape_held = 1'b0;
      if (open_quote != QS_NONE && ch == open_quote_byte()) begin
        store_byte(ch, 1'b0);
        consumed = 1'b1;
      end else begin
        store_byte(CH_BSLASH, 1'b0);
      end
    end

    if (consumed) begin
      // escaped quote already stored
    end else if (ch == CH_NUL) begin
      // line end closes any quote and the open argument
      open_quote = QS_NONE;
      close_argument();
      if (usable_slots() == 0) dropped_any = 1'b1;
      add_result(CH_NUL, 1'b0, 1'b1);
      clear_line_state();
    end else if (ch == CH_SPACE || ch == CH_TAB) begin
      if (open_quote == QS_NONE) begin
        close_argument();
      end else begin
        between_args = 1'b0;
        store_byte(ch, 1'b0);
      end
    end else if (ch == CH_SQUOTE || ch == CH_DQUOTE) begin
      between_args = 1'b0;
      if (open_quote == QS_NONE) begin
        open_quote = (ch == CH_SQUOTE) ? QS_SINGLE : QS_DOUBLE;
        if (keep_quotes) store_byte(ch, 1'b0);
      end else if (ch == open_quote_byte()) begin
        open_quote = QS_NONE;
        if (keep_quotes) store_byte(ch, 1'b0);
      end else begin
        // the other quote inside a quote is plain text
        store_byte(ch, 1'b0);
      end
    end else if (ch == CH_BSLASH && open_quote != QS_NONE) begin
      between_args = 1'b0;
      escape_held  = 1'b1;
    end else begin
      between_args = 1'b0;
      store_byte(ch, 1'b0);
    end

    if (step_beats_q.size() != 0) step_beats_q[step_beats_q.size()-1].last = 1'b1;
    foreach (step_beats_q[i]) due_beats_q.push_back(step_beats_q[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // driver and monitor
  // ---------------------------------------------------------------------------

  // line side: present the next byte once the previous beat is gone
  always @(negedge clk_i) begin
    if (!line_if.valid || line_beat_taken) begin
      line_beat_taken = 1'b0;
      if (line_gap == 0 && idle_on && $urandom_range(0, 11) == 0)
        line_gap = $urandom_range(1, 15);
      if (line_gap > 0) begin
        line_gap--;
        line_if.valid <= 1'b0;
      end else if (line_bytes_q.size() != 0) begin
        line_if.valid <= 1'b1;
        line_if.ch    <= line_bytes_q.pop_front();
      end else begin
        line_if.valid <= 1'b0;
      end
    end
  end

  // result side: back-pressure in random bursts
  always @(negedge clk_i) begin
    if (sink_stall == 0 && idle_on && $urandom_range(0, 9) == 0)
      sink_stall = $urandom_range(1, 15);
    if (sink_stall > 0) begin
      sink_stall--;
      tok_if.ready <= 1'b0;
    end else begin
      tok_if.ready <= 1'b1;
    end
  end

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  // sample both channels at the rising edge; predict before checking
  always @(posedge clk_i) begin
    tok_beat_t seen;
    tok_beat_t want;
    if (rst_ni) begin
      if (line_if.valid && line_if.ready) begin
        tokenize_byte(line_if.ch);
        line_beat_taken = 1'b1;
        bytes_taken++;
      end
      if (tok_if.valid && tok_if.ready) begin
        seen.res.out_byte     = tok_if.out_byte;
        seen.res.is_separator = tok_if.is_separator;
        seen.res.end_of_line  = tok_if.end_of_line;
        seen.res.arg_count    = tok_if.arg_count;
        seen.res.overflow     = tok_if.overflow;
        seen.last             = tok_if.last;
        if (due_beats_q.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing due, byte %02h", seen.res.out_byte));
        end else begin
          want = due_beats_q.pop_front();
          if (seen != want)
            report_mismatch($sformatf(
              "byte %02h/%02h sep %0b/%0b eol %0b/%0b args %0d/%0d ovf %0b/%0b last %0b/%0b",
              seen.res.out_byte, want.res.out_byte,
              seen.res.is_separator, want.res.is_separator,
              seen.res.end_of_line, want.res.end_of_line,
              seen.res.arg_count, want.res.arg_count,
              seen.res.overflow, want.res.overflow,
              seen.last, want.last));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void push_byte(logic [7:0] b);
    line_bytes_q.push_back(b);
    bytes_queued++;
  endfunction

  // a byte with no special meaning anywhere, mostly letters
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    if ($urandom_range(0, 2) != 0) return 8'h61 + 8'($urandom_range(0, 25));
    do b = 8'($urandom_range(1, 255));
    while (b == CH_SPACE || b == CH_TAB || b == CH_SQUOTE || b == CH_DQUOTE || b == CH_BSLASH);
    return b;
  endfunction

  function automatic void push_blanks();
    repeat ($urandom_range(1, 3)) push_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
  endfunction

  // one command line, mostly well formed, ending in a zero byte
  function automatic void add_line();
    int         words;
    logic [7:0] q;
    logic [7:0] other;

    // noise line: raw bytes, a stray zero may end it early
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(0, 255)));
      push_byte(CH_NUL);
      return;
    end

    words = $urandom_range(0, 5);
    if ($urandom_range(0, 2) == 0) push_blanks();
    for (int k = 0; k < words; k++) begin
      q     = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
      other = (q == CH_SQUOTE) ? CH_DQUOTE : CH_SQUOTE;
      case ($urandom_range(0, 3))
        0, 1: begin
          // bare word, backslash is ordinary here
          repeat ($urandom_range(1, 5))
            push_byte($urandom_range(0, 7) == 0 ? CH_BSLASH : plain_byte());
        end
        2: begin
          // quoted word with escapes, blanks and the other quote inside
          push_byte(q);
          repeat ($urandom_range(0, 5)) begin
            case ($urandom_range(0, 5))
              0: begin push_byte(CH_BSLASH); push_byte(q); end
              1: begin push_byte(CH_BSLASH); push_byte($urandom_range(0, 1) ? CH_BSLASH : other); end
              2: push_byte(other);
              3: push_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
              default: push_byte(plain_byte());
            endcase
          end
          // sometimes left open so the line end closes it
          if ($urandom_range(0, 7) != 0) push_byte(q);
        end
        default: begin
          // quote glued to bare text
          push_byte(plain_byte());
          push_byte(q);
          push_byte(plain_byte());
          push_byte(q);
          push_byte(plain_byte());
        end
      endcase
      if (k < words - 1 || $urandom_range(0, 1) == 0) push_blanks();
    end
    if ($urandom_range(0, 7) == 0) push_byte(CH_BSLASH);
    push_byte(CH_NUL);
  endfunction

  // register writes go out at the falling edge, model copy follows
  task automatic cfg_write(at_cfg_idx_e idx, logic [AT_LIMIT_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      AT_CFG_STORE_QUOTES: keep_quotes = val[0];
      default:             limit_reg   = val;
    endcase
  endtask

  // wait until every byte is taken and every result seen, then settle
  task automatic drain();
    while (bytes_taken != bytes_queued || due_beats_q.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic run_lines(bit sq, logic [AT_LIMIT_W-1:0] lim, bit idle, int n_bytes);
    int start;
    idle_on = idle;
    cfg_write(AT_CFG_STORE_QUOTES, AT_LIMIT_W'(sq));
    cfg_write(AT_CFG_BUFFER_LIMIT, lim);
    start = bytes_queued;
    while (bytes_queued - start < n_bytes) add_line();
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  initial begin
    // directed line: top byte, double blank, other quote inside a quote,
    // escaped quote, backslash before plain text, tab inside a quote,
    // bare backslash, backslash at line end inside an open quote,
    // then an empty line and an argument made of empty quotes
    logic [7:0] opening_bytes [23] = '{
      8'h61, 8'hFF, CH_SPACE, CH_SPACE, CH_SQUOTE, CH_DQUOTE, CH_BSLASH, CH_SQUOTE,
      CH_BSLASH, 8'h71, CH_TAB, CH_SQUOTE, CH_TAB, CH_BSLASH, CH_DQUOTE, CH_BSLASH,
      CH_NUL, CH_NUL, 8'h01, CH_TAB, CH_DQUOTE, CH_DQUOTE, CH_NUL};

    rst_ni        = 1'b0;
    line_if.valid = 1'b0;
    line_if.ch    = '0;
    tok_if.ready  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = AT_CFG_STORE_QUOTES;
    cfg_wdata_i   = '0;
    idle_on       = 1'b1;
    keep_quotes   = 1'b0;
    limit_reg     = AT_LIMIT_RESET;
    clear_line_state();

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset register values first
    foreach (opening_bytes[i]) push_byte(opening_bytes[i]);
    drain();

    // random lines across register settings, extremes included
    run_lines(1'b1, 13'd8191, 1'b1, 40);
    run_lines(1'b0, 13'd0,    1'b1, 30);
    run_lines(1'b1, 13'd1,    1'b0, 25);
    run_lines(1'b0, 13'd2,    1'b1, 25);
    run_lines(1'b1, 13'($urandom_range(3, 40)), 1'b1, 40);
    run_lines(1'b0, 13'($urandom_range(5, 60)), 1'b1, 40);

    run_lines(1'($urandom_range(0, 1)), 13'd4096, 1'b1, 40);
    // closing stretch at full rate on both sides
    run_lines(1'($urandom_range(0, 1)), 13'd4096, 1'b0, 50);

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // hard stop well past the slowest correct run
  initial begin
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/at_pkg.sv
rtl/at_if.sv
rtl/at_front.sv
rtl/at_queue.sv
rtl/at_back.sv
rtl/argument_tokenizer.sv
bench/tb_top.sv
